// ----- rtl/core/tdfsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tdfsm_pkg
// Shared types and codes of the table-driven state machine engine.
// ----------------------------------------------------------------------------
package tdfsm_pkg;

   localparam int KIND_W   = 2;
   localparam int FIELD_W  = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_SEND    = 2'd0,
      KIND_ADD_REG = 2'd1,
      KIND_ADD_ERR = 2'd2,
      KIND_ADD_ABS = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_NOMATCH = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      TBL_ERR,
      TBL_ABS,
      TBL_REG
   } table_sel_type;

   typedef enum logic [2:0] {
      TOP_IDLE,
      TOP_SEARCH,
      TOP_APPEND,
      TOP_DONE
   } top_state_type;

   typedef enum logic {
      SRCH_IDLE,
      SRCH_SCAN
   } srch_state_type;

   typedef struct packed {
      logic done;
      logic hit;
   } srch_status_type;

endpackage

// ----- rtl/core/tdfsm_if.sv -----
// ----------------------------------------------------------------------------
// tdfsm channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdfsm_req_if;
   import tdfsm_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [FIELD_W-1:0] from_state;
   logic [FIELD_W-1:0] symbol;
   logic [FIELD_W-1:0] to_state;

   modport source (output valid, kind, from_state, symbol, to_state, input ready);
   modport sink (input valid, kind, from_state, symbol, to_state, output ready);
endinterface

interface tdfsm_rsp_if;
   import tdfsm_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FIELD_W-1:0]  present_state;
   logic [FIELD_W-1:0]  last_symbol;

   modport source (output valid, status, present_state, last_symbol, input ready);
   modport sink (input valid, status, present_state, last_symbol, output ready);
endinterface

interface tdfsm_csr_if;
   import tdfsm_pkg::*;
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/tdfsm_table_ram.sv -----
// ----------------------------------------------------------------------------
// tdfsm_table_ram
// One transition table: single write port, single registered read port.
// ----------------------------------------------------------------------------
module tdfsm_table_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tdfsm_search.sv -----
// ----------------------------------------------------------------------------
// tdfsm_search
// Scans error, absolute then regular table one entry a cycle through a
// single shared compare unit; stops at the first matching entry.
// ----------------------------------------------------------------------------
module tdfsm_search #(
   parameter int REGULAR_DEPTH  = 64,
   parameter int ERROR_DEPTH    = 16,
   parameter int ABSOLUTE_DEPTH = 16,
   parameter int STATE_BITS     = 8,
   localparam int MAX_DEPTH  = (REGULAR_DEPTH > ERROR_DEPTH) ?
                               ((REGULAR_DEPTH > ABSOLUTE_DEPTH) ? REGULAR_DEPTH : ABSOLUTE_DEPTH) :
                               ((ERROR_DEPTH > ABSOLUTE_DEPTH) ? ERROR_DEPTH : ABSOLUTE_DEPTH),
   localparam int IDX_W      = $clog2(MAX_DEPTH + 1),
   localparam int REG_AW     = (REGULAR_DEPTH > 1) ? $clog2(REGULAR_DEPTH) : 1,
   localparam int ERR_AW     = (ERROR_DEPTH > 1) ? $clog2(ERROR_DEPTH) : 1,
   localparam int ABS_AW     = (ABSOLUTE_DEPTH > 1) ? $clog2(ABSOLUTE_DEPTH) : 1,
   localparam int SHORT_W    = STATE_BITS + tdfsm_pkg::FIELD_W,
   localparam int LONG_W     = 2 * STATE_BITS + tdfsm_pkg::FIELD_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [STATE_BITS-1:0]        cur_state,
   input  logic [tdfsm_pkg::FIELD_W-1:0] symbol,
   input  logic [IDX_W-1:0]             err_count,
   input  logic [IDX_W-1:0]             abs_count,
   input  logic [IDX_W-1:0]             reg_count,
   output logic [ERR_AW-1:0]            err_rd_addr,
   output logic [ABS_AW-1:0]            abs_rd_addr,
   output logic [REG_AW-1:0]            reg_rd_addr,
   input  logic [SHORT_W-1:0]           err_rd_data,
   input  logic [SHORT_W-1:0]           abs_rd_data,
   input  logic [LONG_W-1:0]            reg_rd_data,
   output tdfsm_pkg::srch_status_type   status,
   output logic [STATE_BITS-1:0]        dst
);
   import tdfsm_pkg::*;

   srch_state_type state_ff, state_in;
   table_sel_type  tbl_ff, tbl_in;
   table_sel_type  cmp_tbl_ff, cmp_tbl_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             cmp_valid_ff, cmp_valid_in;

   logic [IDX_W-1:0]      cur_count;
   logic [FIELD_W-1:0]    ent_sym;
   logic [STATE_BITS-1:0] ent_dst;
   logic [STATE_BITS-1:0] ent_src;
   logic                  hit;
   logic                  exhausted;

   assign err_rd_addr = idx_ff[ERR_AW-1:0];
   assign abs_rd_addr = idx_ff[ABS_AW-1:0];
   assign reg_rd_addr = idx_ff[REG_AW-1:0];

   always_comb begin
      unique case (tbl_ff)
         TBL_ERR: cur_count = err_count;
         TBL_ABS: cur_count = abs_count;
         default: cur_count = reg_count;
      endcase
   end

   // shared compare unit, fed by the table whose read is in flight
   always_comb begin
      unique case (cmp_tbl_ff)
         TBL_ERR: begin
            ent_sym = err_rd_data[SHORT_W-1:STATE_BITS];
            ent_dst = err_rd_data[STATE_BITS-1:0];
         end
         TBL_ABS: begin
            ent_sym = abs_rd_data[SHORT_W-1:STATE_BITS];
            ent_dst = abs_rd_data[STATE_BITS-1:0];
         end
         default: begin
            ent_sym = reg_rd_data[SHORT_W-1:STATE_BITS];
            ent_dst = reg_rd_data[STATE_BITS-1:0];
         end
      endcase
   end

   assign ent_src   = reg_rd_data[LONG_W-1:SHORT_W];
   assign hit       = cmp_valid_ff && (ent_sym == symbol) &&
                      ((cmp_tbl_ff != TBL_REG) || (ent_src == cur_state));
   assign exhausted = !cmp_valid_ff && (tbl_ff == TBL_REG) && (idx_ff >= reg_count);
   assign dst       = ent_dst;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SRCH_IDLE;
         tbl_ff       <= TBL_ERR;
         cmp_tbl_ff   <= TBL_ERR;
         idx_ff       <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tbl_ff       <= tbl_in;
         cmp_tbl_ff   <= cmp_tbl_in;
         idx_ff       <= idx_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      tbl_in       = tbl_ff;
      cmp_tbl_in   = cmp_tbl_ff;
      idx_in       = idx_ff;
      cmp_valid_in = 1'b0;
      status.done  = 1'b0;
      status.hit   = 1'b0;
      unique case (state_ff)
         SRCH_IDLE: begin
            if (start) begin
               state_in = SRCH_SCAN;
               tbl_in   = TBL_ERR;
               idx_in   = '0;
            end
         end
         SRCH_SCAN: begin
            if (hit || exhausted) begin
               status.done = 1'b1;
               status.hit  = hit;
               state_in    = SRCH_IDLE;
            end else if (idx_ff < cur_count) begin
               // issue the next read; its data is compared next cycle
               idx_in       = idx_ff + IDX_W'(1);
               cmp_valid_in = 1'b1;
               cmp_tbl_in   = tbl_ff;
            end else if (tbl_ff != TBL_REG) begin
               tbl_in = (tbl_ff == TBL_ERR) ? TBL_ABS : TBL_REG;
               idx_in = '0;
            end
         end
         default: state_in = SRCH_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/table_driven_fsm_engine.sv -----
// ----------------------------------------------------------------------------
// table_driven_fsm_engine
// Programmable state machine driven by error, absolute and regular tables.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. An append (regular, error or absolute
// transition) answers once the output register is free. A send-symbol beat
// walks the error, absolute and regular tables in that order through one
// shared compare unit, one entry a cycle from a registered table read, and
// stops at the first match. A finished response sits in an output register;
// the next request is taken while it waits. A write on the csr channel loads
// the current state at once and is meant for idle periods only. Tables need
// no clearing after reset.
// ----------------------------------------------------------------------------
module table_driven_fsm_engine #(
   parameter int REGULAR_DEPTH  = 64,
   parameter int ERROR_DEPTH    = 16,
   parameter int ABSOLUTE_DEPTH = 16,
   parameter int STATE_BITS     = 8
) (
   input  logic        clock,
   input  logic        reset,
   tdfsm_req_if.sink   req_ch,
   tdfsm_rsp_if.source rsp_ch,
   tdfsm_csr_if.sink   csr_ch
);
   import tdfsm_pkg::*;

   localparam int MAX_DEPTH = (REGULAR_DEPTH > ERROR_DEPTH) ?
                              ((REGULAR_DEPTH > ABSOLUTE_DEPTH) ? REGULAR_DEPTH : ABSOLUTE_DEPTH) :
                              ((ERROR_DEPTH > ABSOLUTE_DEPTH) ? ERROR_DEPTH : ABSOLUTE_DEPTH);
   localparam int IDX_W   = $clog2(MAX_DEPTH + 1);
   localparam int REG_AW  = (REGULAR_DEPTH > 1) ? $clog2(REGULAR_DEPTH) : 1;
   localparam int ERR_AW  = (ERROR_DEPTH > 1) ? $clog2(ERROR_DEPTH) : 1;
   localparam int ABS_AW  = (ABSOLUTE_DEPTH > 1) ? $clog2(ABSOLUTE_DEPTH) : 1;
   localparam int REG_CW  = $clog2(REGULAR_DEPTH + 1);
   localparam int ERR_CW  = $clog2(ERROR_DEPTH + 1);
   localparam int ABS_CW  = $clog2(ABSOLUTE_DEPTH + 1);
   localparam int SHORT_W = STATE_BITS + FIELD_W;
   localparam int LONG_W  = 2 * STATE_BITS + FIELD_W;

   top_state_type state_ff, state_in;

   // held request beat
   kind_type              kind_ff;
   logic [STATE_BITS-1:0] from_ff;
   logic [FIELD_W-1:0]    sym_ff;
   logic [STATE_BITS-1:0] to_ff;

   logic [STATE_BITS-1:0] cur_ff, cur_in;
   logic [FIELD_W-1:0]    acc_sym_ff, acc_sym_in;
   logic [REG_CW-1:0]     reg_cnt_ff, reg_cnt_in;
   logic [ERR_CW-1:0]     err_cnt_ff, err_cnt_in;
   logic [ABS_CW-1:0]     abs_cnt_ff, abs_cnt_in;
   logic                  hit_ff, hit_in;
   logic [STATE_BITS-1:0] dst_ff, dst_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]    rsp_state_ff, rsp_state_in;
   logic [FIELD_W-1:0]    rsp_sym_ff, rsp_sym_in;

   logic                  req_accept;
   logic                  csr_write;
   logic                  slot_free;
   logic                  load_rsp;
   logic                  srch_start;
   srch_status_type       srch_status;
   logic [STATE_BITS-1:0] srch_dst;

   logic [STATE_BITS+FIELD_W-1:0] from_wide;
   logic [STATE_BITS+FIELD_W-1:0] to_wide;
   logic [STATE_BITS+FIELD_W-1:0] csr_wide;
   logic [STATE_BITS+FIELD_W-1:0] cur_wide;

   logic                  reg_wr_en, err_wr_en, abs_wr_en;
   logic [LONG_W-1:0]     reg_wr_data;
   logic [SHORT_W-1:0]    short_wr_data;
   logic [ERR_AW-1:0]     err_rd_addr;
   logic [ABS_AW-1:0]     abs_rd_addr;
   logic [REG_AW-1:0]     reg_rd_addr;
   logic [SHORT_W-1:0]    err_rd_data;
   logic [SHORT_W-1:0]    abs_rd_data;
   logic [LONG_W-1:0]     reg_rd_data;

   assign req_ch.ready = (state_ff == TOP_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_write    = csr_ch.valid && csr_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign srch_start   = req_accept && (kind_type'(req_ch.kind) == KIND_SEND);

   // state values fit STATE_BITS; widen first so any width works both ways
   assign from_wide = {{STATE_BITS{1'b0}}, req_ch.from_state};
   assign to_wide   = {{STATE_BITS{1'b0}}, req_ch.to_state};
   assign csr_wide  = {{STATE_BITS{1'b0}}, csr_ch.data};
   assign cur_wide  = {{FIELD_W{1'b0}}, cur_in};

   assign reg_wr_data   = {from_ff, sym_ff, to_ff};
   assign short_wr_data = {sym_ff, to_ff};

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= kind_type'(req_ch.kind);
         from_ff <= from_wide[STATE_BITS-1:0];
         sym_ff  <= req_ch.symbol;
         to_ff   <= to_wide[STATE_BITS-1:0];
      end
      hit_ff        <= hit_in;
      dst_ff        <= dst_in;
      rsp_status_ff <= rsp_status_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_sym_ff    <= rsp_sym_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         cur_ff       <= '0;
         acc_sym_ff   <= '0;
         reg_cnt_ff   <= '0;
         err_cnt_ff   <= '0;
         abs_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         acc_sym_ff   <= acc_sym_in;
         reg_cnt_ff   <= reg_cnt_in;
         err_cnt_ff   <= err_cnt_in;
         abs_cnt_ff   <= abs_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      acc_sym_in    = acc_sym_ff;
      reg_cnt_in    = reg_cnt_ff;
      err_cnt_in    = err_cnt_ff;
      abs_cnt_in    = abs_cnt_ff;
      hit_in        = hit_ff;
      dst_in        = dst_ff;
      rsp_status_in = rsp_status_ff;
      load_rsp      = 1'b0;
      reg_wr_en     = 1'b0;
      err_wr_en     = 1'b0;
      abs_wr_en     = 1'b0;
      unique case (state_ff)
         TOP_IDLE: begin
            if (req_accept) begin
               state_in = srch_start ? TOP_SEARCH : TOP_APPEND;
            end
         end
         TOP_SEARCH: begin
            if (srch_status.done) begin
               hit_in   = srch_status.hit;
               dst_in   = srch_dst;
               state_in = TOP_DONE;
            end
         end
         TOP_DONE: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               state_in = TOP_IDLE;
               if (hit_ff) begin
                  cur_in        = dst_ff;
                  acc_sym_in    = sym_ff;
                  rsp_status_in = STAT_OK;
               end else begin
                  rsp_status_in = STAT_NOMATCH;
               end
            end
         end
         TOP_APPEND: begin
            if (slot_free) begin
               load_rsp      = 1'b1;
               state_in      = TOP_IDLE;
               rsp_status_in = STAT_OK;
               case (kind_ff)
                  KIND_ADD_REG: begin
                     if (reg_cnt_ff == REG_CW'(REGULAR_DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        reg_wr_en  = 1'b1;
                        reg_cnt_in = reg_cnt_ff + REG_CW'(1);
                     end
                  end
                  KIND_ADD_ERR: begin
                     if (err_cnt_ff == ERR_CW'(ERROR_DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        err_wr_en  = 1'b1;
                        err_cnt_in = err_cnt_ff + ERR_CW'(1);
                     end
                  end
                  default: begin
                     if (abs_cnt_ff == ABS_CW'(ABSOLUTE_DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        abs_wr_en  = 1'b1;
                        abs_cnt_in = abs_cnt_ff + ABS_CW'(1);
                     end
                  end
               endcase
            end
         end
         default: state_in = TOP_IDLE;
      endcase
      if (csr_write) begin
         cur_in = csr_wide[STATE_BITS-1:0];
      end
   end

   // response register: a beat waits here while the next request is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_state_in = rsp_state_ff;
      rsp_sym_in   = rsp_sym_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_state_in = cur_wide[FIELD_W-1:0];
         rsp_sym_in   = acc_sym_in;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.present_state = rsp_state_ff;
   assign rsp_ch.last_symbol   = rsp_sym_ff;

   tdfsm_table_ram #(
      .DEPTH (ERROR_DEPTH),
      .WIDTH (SHORT_W)
   ) u_err_ram (
      .clock   (clock),
      .wr_en   (err_wr_en),
      .wr_addr (err_cnt_ff[ERR_AW-1:0]),
      .wr_data (short_wr_data),
      .rd_addr (err_rd_addr),
      .rd_data (err_rd_data)
   );

   tdfsm_table_ram #(
      .DEPTH (ABSOLUTE_DEPTH),
      .WIDTH (SHORT_W)
   ) u_abs_ram (
      .clock   (clock),
      .wr_en   (abs_wr_en),
      .wr_addr (abs_cnt_ff[ABS_AW-1:0]),
      .wr_data (short_wr_data),
      .rd_addr (abs_rd_addr),
      .rd_data (abs_rd_data)
   );

   tdfsm_table_ram #(
      .DEPTH (REGULAR_DEPTH),
      .WIDTH (LONG_W)
   ) u_reg_ram (
      .clock   (clock),
      .wr_en   (reg_wr_en),
      .wr_addr (reg_cnt_ff[REG_AW-1:0]),
      .wr_data (reg_wr_data),
      .rd_addr (reg_rd_addr),
      .rd_data (reg_rd_data)
   );

   tdfsm_search #(
      .REGULAR_DEPTH  (REGULAR_DEPTH),
      .ERROR_DEPTH    (ERROR_DEPTH),
      .ABSOLUTE_DEPTH (ABSOLUTE_DEPTH),
      .STATE_BITS     (STATE_BITS)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .start       (srch_start),
      .cur_state   (cur_ff),
      .symbol      (sym_ff),
      .err_count   (IDX_W'(err_cnt_ff)),
      .abs_count   (IDX_W'(abs_cnt_ff)),
      .reg_count   (IDX_W'(reg_cnt_ff)),
      .err_rd_addr (err_rd_addr),
      .abs_rd_addr (abs_rd_addr),
      .reg_rd_addr (reg_rd_addr),
      .err_rd_data (err_rd_data),
      .abs_rd_data (abs_rd_data),
      .reg_rd_data (reg_rd_data),
      .status      (srch_status),
      .dst         (srch_dst)
   );

   a_reg_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      reg_cnt_ff <= REG_CW'(REGULAR_DEPTH))
      else $error("regular count beyond table depth");

   a_err_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      err_cnt_ff <= ERR_CW'(ERROR_DEPTH) && abs_cnt_ff <= ABS_CW'(ABSOLUTE_DEPTH))
      else $error("error or absolute count beyond table depth");

   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      srch_status.done |-> state_ff == TOP_SEARCH)
      else $error("search finished outside a send");

   a_search_follows_send: assert property (@(posedge clock) disable iff (reset)
      srch_start |=> state_ff == TOP_SEARCH)
      else $error("send beat did not start a search");

   a_state_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TOP_DONE && slot_free && !hit_ff && !csr_write) |=> $stable(cur_ff))
      else $error("current state changed without a match");

endmodule

// ----- tb/tb_table_driven_fsm_engine.sv -----
// ----------------------------------------------------------------------------
// tb_table_driven_fsm_engine
// Self-checking bench for the table-driven state machine engine. It keeps its
// own copy of the three transition tables, the current state and the last
// accepted symbol. Each request beat is predicted when it is taken. Each
// response beat is compared with the oldest prediction. Stimulus covers
// directed priority cases, initial-state writes, random walks over the tables
// under changing backpressure, and overflow of every table.
// ----------------------------------------------------------------------------
module tb_table_driven_fsm_engine;
   import tdfsm_pkg::*;

   localparam int REG_SLOTS      = 64;
   localparam int ERR_SLOTS      = 16;
   localparam int ABS_SLOTS      = 16;
   localparam int WALK_ITEMS     = 225;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 150;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;

   typedef logic [FIELD_W-1:0] byte_type;

   typedef struct packed {
      byte_type src;
      byte_type sym;
      byte_type dst;
   } arc_type;

   typedef struct packed {
      status_type status;
      byte_type   present_state;
      byte_type   last_symbol;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tdfsm_req_if req_bus ();
   tdfsm_rsp_if rsp_bus ();
   tdfsm_csr_if csr_bus ();

   table_driven_fsm_engine u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #5 clock = ~clock;

   // machine model
   arc_type  reg_arcs [$];
   arc_type  err_arcs [$];
   arc_type  abs_arcs [$];
   byte_type initial_state_reg = '0;
   byte_type cur_state = '0;
   byte_type last_sym = '0;

   outcome_type pending_outcomes [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 1'b0;
   int fail_count = 0;
   int rsp_checked = 0;
   int req_taken = 0;
   int hit_count = 0;
   int nomatch_count = 0;
   int full_count = 0;
   int cfg_writes = 0;

   function automatic bit find_arc(input arc_type arcs[$], input bit match_src,
                                   input byte_type sym, output byte_type dst);
      dst = '0;
      foreach (arcs[i]) begin
         if (arcs[i].sym == sym && (!match_src || arcs[i].src == cur_state)) begin
            dst = arcs[i].dst;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic status_type add_arc(ref arc_type arcs[$], input int depth,
                                          input arc_type entry);
      if (arcs.size() >= depth)
         return STAT_FULL;
      arcs = {arcs, entry};
      return STAT_OK;
   endfunction

   function automatic outcome_type advance_machine(input kind_type kind, input byte_type src,
                                                   input byte_type sym, input byte_type dst);
      outcome_type res;
      byte_type    next_state;
      bit          hit;
      res.status = STAT_OK;
      case (kind)
         KIND_SEND: begin
            hit = find_arc(err_arcs, 1'b0, sym, next_state);
            if (!hit)
               hit = find_arc(abs_arcs, 1'b0, sym, next_state);
            if (!hit)
               hit = find_arc(reg_arcs, 1'b1, sym, next_state);
            if (hit) begin
               cur_state = next_state;
               last_sym  = sym;
               hit_count++;
            end else begin
               res.status = STAT_NOMATCH;
               nomatch_count++;
            end
         end
         KIND_ADD_REG: res.status = add_arc(reg_arcs, REG_SLOTS, '{src, sym, dst});
         KIND_ADD_ERR: res.status = add_arc(err_arcs, ERR_SLOTS, '{'0, sym, dst});
         default:      res.status = add_arc(abs_arcs, ABS_SLOTS, '{'0, sym, dst});
      endcase
      if (res.status == STAT_FULL)
         full_count++;
      res.present_state = cur_state;
      res.last_symbol   = last_sym;
      return res;
   endfunction

   // drivers: every task is entered just after a rising edge
   task automatic send_item(input kind_type kind, input byte_type src, input byte_type sym,
                            input byte_type dst);
      outcome_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.from_state <= src;
      req_bus.symbol     <= sym;
      req_bus.to_state   <= dst;
      do @(posedge clock); while (!req_bus.ready);
      req_taken++;
      predicted = advance_machine(kind, src, sym, dst);
      pending_outcomes = {pending_outcomes, predicted};
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic quiesce();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_initial_state(input byte_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      initial_state_reg = value;
      cur_state = initial_state_reg;
      cfg_writes++;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_random_item();
      int       roll;
      byte_type sym;
      byte_type picks [$];
      roll = $urandom_range(99);
      if (roll < 10) begin
         // mostly chain a new arc off the state the machine sits in
         send_item(KIND_ADD_REG, ($urandom_range(9) < 7) ? cur_state : byte_type'($urandom),
                   byte_type'($urandom), byte_type'($urandom));
      end else if (roll < 11) begin
         send_item(KIND_ADD_ERR, byte_type'($urandom), byte_type'($urandom),
                   byte_type'($urandom));
      end else if (roll < 12) begin
         send_item(KIND_ADD_ABS, byte_type'($urandom), byte_type'($urandom),
                   byte_type'($urandom));
      end else begin
         sym  = byte_type'($urandom);
         roll = $urandom_range(99);
         if (roll < 65) begin
            foreach (reg_arcs[i])
               if (reg_arcs[i].src == cur_state)
                  picks = {picks, reg_arcs[i].sym};
         end else if (roll < 75) begin
            foreach (err_arcs[i]) picks = {picks, err_arcs[i].sym};
            foreach (abs_arcs[i]) picks = {picks, abs_arcs[i].sym};
         end
         if (picks.size() != 0)
            sym = picks[$urandom_range(picks.size() - 1)];
         send_item(KIND_SEND, byte_type'($urandom), sym, byte_type'($urandom));
      end
   endtask

   // response side: ready pattern, long hold-off and result check
   initial begin
      int hold_left;
      outcome_type want;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_checked++;
            if (pending_outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected response beat: status %0d state %02h symbol %02h",
                           rsp_bus.status, rsp_bus.present_state, rsp_bus.last_symbol);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_bus.status !== want.status ||
                   rsp_bus.present_state !== want.present_state ||
                   rsp_bus.last_symbol !== want.last_symbol) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("response %0d mismatch: expected status %0d state %02h ",
                              rsp_checked, want.status, want.present_state,
                              "symbol %02h, got status %0d state %02h symbol %02h",
                              want.last_symbol, rsp_bus.status, rsp_bus.present_state,
                              rsp_bus.last_symbol);
               end
            end
         end
         if (hold_request && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_outcomes.size());
            $display("** table_driven_fsm_engine: FAILED **");
            $finish;
         end
      end
   end

   task automatic test_empty_tables();
      send_item(KIND_SEND, 8'h00, 8'h00, 8'h00);
      send_item(KIND_SEND, 8'hFF, 8'hFF, 8'hFF);
   endtask

   task automatic test_table_priority();
      send_item(KIND_ADD_REG, 8'h00, 8'hFF, 8'hFF);
      send_item(KIND_ADD_REG, 8'h00, 8'hFF, 8'h11);   // shadowed by the older arc
      send_item(KIND_ADD_REG, 8'hFF, 8'h00, 8'h80);
      send_item(KIND_ADD_REG, 8'h80, 8'h5A, 8'h00);
      send_item(KIND_SEND, 8'h00, 8'hFF, 8'h00);
      send_item(KIND_SEND, 8'h00, 8'hFF, 8'h00);      // wrong source state
      send_item(KIND_SEND, 8'hFF, 8'h00, 8'hFF);
      send_item(KIND_SEND, 8'h00, 8'h5A, 8'h00);
      send_item(KIND_ADD_ABS, 8'hFF, 8'h5A, 8'h33);
      send_item(KIND_SEND, 8'h00, 8'h5A, 8'h00);      // absolute ignores state
      send_item(KIND_ADD_REG, 8'h33, 8'hA5, 8'h44);
      send_item(KIND_ADD_ERR, 8'hAA, 8'hA5, 8'h00);
      send_item(KIND_SEND, 8'h00, 8'hA5, 8'h00);      // error beats regular
      send_item(KIND_ADD_ABS, 8'h55, 8'hA5, 8'h77);
      send_item(KIND_SEND, 8'h00, 8'hA5, 8'h00);
      send_item(KIND_ADD_ERR, 8'h00, 8'h3C, 8'hC3);
      send_item(KIND_ADD_ABS, 8'h00, 8'h3C, 8'h99);
      send_item(KIND_SEND, 8'h00, 8'h3C, 8'h00);      // error beats absolute
      send_item(KIND_SEND, 8'hFF, 8'h42, 8'hFF);
   endtask

   task automatic test_initial_state_write();
      quiesce();
      write_initial_state(8'hFF);
      send_item(KIND_SEND, 8'h00, 8'h00, 8'h00);
      quiesce();
      write_initial_state(8'h00);
      send_item(KIND_SEND, 8'h00, 8'hFF, 8'h00);
      send_item(KIND_SEND, 8'h00, 8'h77, 8'h00);
   endtask

   task automatic test_random_walk(input int sender_pct, input int receiver_pct);
      quiesce();
      write_initial_state(byte_type'($urandom));
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      repeat (WALK_ITEMS) send_random_item();
   endtask

   task automatic test_output_backpressure();
      drain_results();
      hold_request = 1'b1;
      repeat (12) send_random_item();
      // sender waits out everything in flight
      drain_results();
   endtask

   task automatic test_table_overflow();
      quiesce();
      write_initial_state(8'h00);
      while (err_arcs.size() < ERR_SLOTS)
         send_item(KIND_ADD_ERR, byte_type'($urandom), byte_type'($urandom),
                   byte_type'($urandom));
      send_item(KIND_ADD_ERR, 8'hFF, 8'hFF, 8'hFF);
      while (abs_arcs.size() < ABS_SLOTS)
         send_item(KIND_ADD_ABS, byte_type'($urandom), byte_type'($urandom),
                   byte_type'($urandom));
      send_item(KIND_ADD_ABS, 8'hFF, 8'hFF, 8'hFF);
      while (reg_arcs.size() < REG_SLOTS)
         send_item(KIND_ADD_REG, cur_state, byte_type'($urandom), byte_type'($urandom));
      send_item(KIND_ADD_REG, 8'hFF, 8'hFF, 8'hFF);
      send_item(KIND_SEND, 8'h00, err_arcs[ERR_SLOTS-1].sym, 8'h00);
      send_item(KIND_SEND, 8'h00, abs_arcs[ABS_SLOTS-1].sym, 8'h00);
      repeat (4) send_random_item();
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_SEND;
      req_bus.from_state = '0;
      req_bus.symbol     = '0;
      req_bus.to_state   = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.data       = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      recv_idle_pct = 71;
      test_empty_tables();
      test_table_priority();
      test_initial_state_write();
      test_random_walk(20, 71);
      test_random_walk(71, 20);
      test_output_backpressure();
      test_random_walk(0, 0);
      test_table_overflow();

      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0)
         fail_count++;

      $display("covered %0d request beats: %0d transitions, %0d unmatched symbols, %0d refused",
               req_taken, hit_count, nomatch_count, full_count);
      $display("appends to full tables; %0d initial-state writes, %0d responses checked",
               cfg_writes, rsp_checked);
      if (fail_count == 0) begin
         $display("** table_driven_fsm_engine: PASSED **");
      end else begin
         $display("%0d failures", fail_count);
         $display("** table_driven_fsm_engine: FAILED **");
      end
      $finish;
   end

endmodule
